// ----- src/xcfb_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfb_pkg
// Shared widths, character codes, input modes, register indexes and the
// frame-kind state type of the XOR-checked frame builder.
// ----------------------------------------------------------------------------
package xcfb_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int NUM_W      = 24;
  localparam int MODE_W     = 3;
  localparam int SIZE_REG_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Result burst: longest frame produced by one transaction
  localparam int BURST_MAX = 8;
  localparam int BCNT_W    = 4;

  // Largest file block size, default
  localparam int BLOCK_MAX_DEF = 4096;

  // Register reset values
  localparam logic [SIZE_REG_W-1:0] BLOCK_SIZE_RST = 13'd4096;
  localparam logic [BYTE_W-1:0]     BLOCK_END_RST  = 8'd23;

  // Framing characters
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_HANDSHAKE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REPEAT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FILE_START = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PAYLOAD    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PAD        = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TEXT_START = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TEXT_CHAR  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_TEXT_END   = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_END  = 2'd1;

  // Open frame kind, one-hot
  typedef enum logic [2:0] {
    KIND_NONE = 3'b001,
    KIND_FILE = 3'b010,
    KIND_TEXT = 3'b100
  } kind_t;

endpackage

// ----- src/xcfb_in_if.sv -----
// ----------------------------------------------------------------------------
// xcfb_in_if
// Input channel: one framing command per transaction.
// ----------------------------------------------------------------------------
interface xcfb_in_if;
  logic                              valid;
  logic                              ready;
  logic [xcfb_pkg::MODE_W-1:0]       mode;
  logic [xcfb_pkg::NUM_W-1:0]        number;
  logic [xcfb_pkg::NUM_W-1:0]        total;
  logic [xcfb_pkg::BYTE_W-1:0]       data;

  modport source (output valid, output mode, output number, output total,
                  output data, input ready);
  modport sink   (input valid, input mode, input number, input total,
                  input data, output ready);
endinterface

// ----- src/xcfb_out_if.sv -----
// ----------------------------------------------------------------------------
// xcfb_out_if
// Result channel: one stream byte with its flags per transaction.
// ----------------------------------------------------------------------------
interface xcfb_out_if;
  logic                        valid;
  logic                        ready;
  logic [xcfb_pkg::BYTE_W-1:0] out_byte;
  logic                        frame_end;
  logic                        run_last;
  logic                        error;

  modport source (output valid, output out_byte, output frame_end,
                  output run_last, output error, input ready);
  modport sink   (input valid, input out_byte, input frame_end,
                  input run_last, input error, output ready);
endinterface

// ----- src/xcfb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// xcfb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface xcfb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [xcfb_pkg::CFG_IDX_W-1:0]  index;
  logic [xcfb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/xor_checked_frame_builder_core.sv -----
// Latency: the first result of an accepted transaction is offered in the next cycle.
// Throughput: one result per cycle from a shifting burst register unless out_ch.ready
// is low; a command of N results holds the input until its last is taken (handshake 8,
// repeat 7, file start 6, block close 3, text start/end 2, payload/pad/char 1).
// Reset (rst_n low, synchronous): no frame open, checksum and fill cleared, burst
// empty, block_size back to 4096 and block_end_char to 23.
// ----------------------------------------------------------------------------
// xor_checked_frame_builder_core
// Builds SOH ... checksum framed handshake, repeat request, file block and
// text frames from a command stream, one output byte per transaction.
// ----------------------------------------------------------------------------
module xor_checked_frame_builder_core #(
  parameter int BLOCK_MAX = xcfb_pkg::BLOCK_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  xcfb_in_if.sink         in_ch,
  xcfb_out_if.source      out_ch,
  xcfb_cfg_if.sink        cfg_ch
);

  localparam int SIZE_W = ($clog2(BLOCK_MAX + 1) > xcfb_pkg::SIZE_REG_W) ?
                          $clog2(BLOCK_MAX + 1) : xcfb_pkg::SIZE_REG_W;
  localparam logic [SIZE_W-1:0] BLOCK_MAX_V = SIZE_W'(BLOCK_MAX);
  localparam int BW = xcfb_pkg::BYTE_W;
  localparam int SW = xcfb_pkg::SIZE_REG_W;

  // Configuration registers
  logic [SW-1:0]         block_size_r;
  logic [BW-1:0]         block_end_r;

  // Frame state
  xcfb_pkg::kind_t       kind_r, kind_nxt;
  logic [BW-1:0]         xor_r, xor_nxt;
  logic [SW-1:0]         fill_r, fill_nxt;
  logic                  more_r, more_nxt;

  // Result burst
  logic [BW-1:0]                 bst_r   [xcfb_pkg::BURST_MAX];
  logic [BW-1:0]                 bst_nxt [xcfb_pkg::BURST_MAX];
  logic [xcfb_pkg::BCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          close_r, close_nxt;
  logic                          err_r, err_nxt;

  logic                  in_fire, out_fire;
  logic [SIZE_W-1:0]     eff_size;
  logic [SW-1:0]         fill_inc;
  logic                  full;
  logic [BW-1:0]         fill_b, term_b;
  logic                  ok;

  // Handshakes
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign out_fire    = out_ch.valid & out_ch.ready;
  assign in_ch.ready = (cnt_r == '0) ||
                       ((cnt_r == xcfb_pkg::BCNT_W'(1)) && out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // Result port
  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.out_byte  = bst_r[0];
  assign out_ch.run_last  = (cnt_r == xcfb_pkg::BCNT_W'(1));
  assign out_ch.frame_end = out_ch.run_last & close_r;
  assign out_ch.error     = err_r;

  // Effective block size, clamped to 1..BLOCK_MAX
  always_comb begin
    eff_size = SIZE_W'(block_size_r);
    if (eff_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (eff_size > BLOCK_MAX_V) begin
      eff_size = BLOCK_MAX_V;
    end
  end

  assign fill_inc = fill_r + SW'(1);
  assign full     = (SIZE_W'(fill_inc) >= eff_size);
  assign fill_b   = (in_ch.mode == xcfb_pkg::MODE_PAD) ? xcfb_pkg::CH_NUL : in_ch.data;
  assign term_b   = more_r ? block_end_r : xcfb_pkg::CH_ETX;

  // Order check against the open frame
  always_comb begin
    unique case (in_ch.mode) inside
      xcfb_pkg::MODE_PAYLOAD,
      xcfb_pkg::MODE_PAD:       ok = (kind_r == xcfb_pkg::KIND_FILE);
      xcfb_pkg::MODE_TEXT_CHAR,
      xcfb_pkg::MODE_TEXT_END:  ok = (kind_r == xcfb_pkg::KIND_TEXT);
      default:                  ok = (kind_r == xcfb_pkg::KIND_NONE);
    endcase
  end

  // Frame bytes, checksum and next state for one command
  always_comb begin
    for (int i = 0; i < xcfb_pkg::BURST_MAX; i++) begin
      bst_nxt[i] = xcfb_pkg::CH_NUL;
    end
    cnt_nxt   = xcfb_pkg::BCNT_W'(1);
    close_nxt = 1'b0;
    err_nxt   = 1'b0;
    kind_nxt  = kind_r;
    xor_nxt   = xor_r;
    fill_nxt  = fill_r;
    more_nxt  = more_r;

    if (!ok) begin
      err_nxt = 1'b1;
    end else begin
      unique case (in_ch.mode) inside
        xcfb_pkg::MODE_HANDSHAKE: begin
          bst_nxt[0] = xcfb_pkg::CH_SOH;
          bst_nxt[1] = xcfb_pkg::CH_NUL;
          bst_nxt[2] = in_ch.total[23:16];
          bst_nxt[3] = in_ch.total[15:8];
          bst_nxt[4] = in_ch.total[7:0];
          bst_nxt[5] = xcfb_pkg::CH_STX;
          bst_nxt[6] = xcfb_pkg::CH_ETX;
          bst_nxt[7] = xcfb_pkg::CH_SOH ^ in_ch.total[23:16] ^ in_ch.total[15:8] ^
                       in_ch.total[7:0] ^ xcfb_pkg::CH_STX ^ xcfb_pkg::CH_ETX;
          cnt_nxt    = xcfb_pkg::BCNT_W'(8);
          close_nxt  = 1'b1;
          xor_nxt    = '0;
        end
        xcfb_pkg::MODE_REPEAT: begin
          bst_nxt[0] = xcfb_pkg::CH_SOH;
          bst_nxt[1] = xcfb_pkg::CH_STX;
          bst_nxt[2] = in_ch.number[23:16];
          bst_nxt[3] = in_ch.number[15:8];
          bst_nxt[4] = in_ch.number[7:0];
          bst_nxt[5] = xcfb_pkg::CH_ETX;
          bst_nxt[6] = xcfb_pkg::CH_SOH ^ xcfb_pkg::CH_STX ^ in_ch.number[23:16] ^
                       in_ch.number[15:8] ^ in_ch.number[7:0] ^ xcfb_pkg::CH_ETX;
          cnt_nxt    = xcfb_pkg::BCNT_W'(7);
          close_nxt  = 1'b1;
          xor_nxt    = '0;
        end
        xcfb_pkg::MODE_FILE_START: begin
          bst_nxt[0] = xcfb_pkg::CH_SOH;
          bst_nxt[1] = xcfb_pkg::CH_NUL;
          bst_nxt[2] = in_ch.number[23:16];
          bst_nxt[3] = in_ch.number[15:8];
          bst_nxt[4] = in_ch.number[7:0];
          bst_nxt[5] = xcfb_pkg::CH_STX;
          cnt_nxt    = xcfb_pkg::BCNT_W'(6);
          xor_nxt    = xcfb_pkg::CH_SOH ^ in_ch.number[23:16] ^ in_ch.number[15:8] ^
                       in_ch.number[7:0] ^ xcfb_pkg::CH_STX;
          kind_nxt   = xcfb_pkg::KIND_FILE;
          fill_nxt   = '0;
          more_nxt   = (in_ch.number < in_ch.total);
        end
        xcfb_pkg::MODE_PAYLOAD,
        xcfb_pkg::MODE_PAD: begin
          bst_nxt[0] = fill_b;
          if (full) begin
            // block full: terminator and checksum close it
            bst_nxt[1] = term_b;
            bst_nxt[2] = xor_r ^ fill_b ^ term_b;
            cnt_nxt    = xcfb_pkg::BCNT_W'(3);
            close_nxt  = 1'b1;
            xor_nxt    = '0;
            kind_nxt   = xcfb_pkg::KIND_NONE;
            fill_nxt   = '0;
            more_nxt   = 1'b0;
          end else begin
            xor_nxt    = xor_r ^ fill_b;
            fill_nxt   = fill_inc;
          end
        end
        xcfb_pkg::MODE_TEXT_START: begin
          bst_nxt[0] = xcfb_pkg::CH_SOH;
          bst_nxt[1] = xcfb_pkg::CH_STX;
          cnt_nxt    = xcfb_pkg::BCNT_W'(2);
          xor_nxt    = xcfb_pkg::CH_SOH ^ xcfb_pkg::CH_STX;
          kind_nxt   = xcfb_pkg::KIND_TEXT;
        end
        xcfb_pkg::MODE_TEXT_CHAR: begin
          bst_nxt[0] = in_ch.data;
          xor_nxt    = xor_r ^ in_ch.data;
        end
        xcfb_pkg::MODE_TEXT_END: begin
          bst_nxt[0] = xcfb_pkg::CH_ETX;
          bst_nxt[1] = xor_r ^ xcfb_pkg::CH_ETX;
          cnt_nxt    = xcfb_pkg::BCNT_W'(2);
          close_nxt  = 1'b1;
          xor_nxt    = '0;
          kind_nxt   = xcfb_pkg::KIND_NONE;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= xcfb_pkg::BLOCK_SIZE_RST;
      block_end_r  <= xcfb_pkg::BLOCK_END_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        xcfb_pkg::REG_BLOCK_SIZE: block_size_r <= cfg_ch.data;
        xcfb_pkg::REG_BLOCK_END:  block_end_r  <= cfg_ch.data[BW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame state and burst control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= xcfb_pkg::KIND_NONE;
      xor_r   <= '0;
      fill_r  <= '0;
      more_r  <= 1'b0;
      cnt_r   <= '0;
      close_r <= 1'b0;
      err_r   <= 1'b0;
    end else if (in_fire) begin
      kind_r  <= kind_nxt;
      xor_r   <= xor_nxt;
      fill_r  <= fill_nxt;
      more_r  <= more_nxt;
      cnt_r   <= cnt_nxt;
      close_r <= close_nxt;
      err_r   <= err_nxt;
    end else if (out_fire) begin
      cnt_r   <= cnt_r - xcfb_pkg::BCNT_W'(1);
    end
  end

  // Burst bytes: load on a new transaction, shift down as results leave
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < xcfb_pkg::BURST_MAX; i++) begin
        bst_r[i] <= bst_nxt[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < xcfb_pkg::BURST_MAX - 1; i++) begin
        bst_r[i] <= bst_r[i+1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A rejected command leaves the frame state untouched
  a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !ok) |=> ($stable(kind_r) && $stable(xor_r) && $stable(fill_r) &&
                          $stable(more_r)))
    else $error("frame state changed on a rejected command");

  // Fill count and last-block flag are only live inside a file block
  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r != xcfb_pkg::KIND_FILE) |-> (fill_r == '0 && !more_r))
    else $error("fill state set with no file block open");

  // Checksum is cleared whenever no frame is open
  a_xor_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == xcfb_pkg::KIND_NONE) |-> (xor_r == '0))
    else $error("checksum not cleared after frame close");

  // An error result is always a single-result burst
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && err_r) |-> (out_ch.run_last && !close_r))
    else $error("error result not a lone result");
`endif

endmodule
